/* rtl/core/gfc_pkg.sv */
// gfc_pkg: shared constants, stage word types and arctangent table
// for the gravity feedforward cosine pipeline; no dependencies
`default_nettype none

package gfc_pkg;

  localparam int DATA_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int ANG_W        = 32;
  localparam int VEC_W        = 36;
  localparam int ROT_W        = 33;
  localparam int ATAN_ENTRIES = 24;
  localparam int STAGES_DEF   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CG_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CG_Z     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_MAX = 2'd2;

  localparam logic [ANG_W-1:0] ANG_ZERO  = 32'h0000_0000;
  localparam logic [ANG_W-1:0] ANG_POS90 = 32'h4000_0000;
  localparam logic [ANG_W-1:0] ANG_180   = 32'h8000_0000;
  localparam logic [ANG_W-1:0] ANG_NEG90 = 32'hC000_0000;

  localparam logic signed [ROT_W-1:0] INV_GAIN = 33'sd652032875;

  typedef struct packed {
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vz;
    logic [ANG_W-1:0]         acc;
    logic                     hold;
    logic                     zero;
    logic [DATA_W-1:0]        pitch;
    logic signed [DATA_W-1:0] m;
  } vec_t;

  typedef struct packed {
    logic signed [ROT_W-1:0]  x;
    logic signed [ROT_W-1:0]  y;
    logic signed [ROT_W-1:0]  r;
    logic                     flip;
    logic                     zero;
    logic signed [DATA_W-1:0] m;
  } rot_t;

  function automatic logic [ANG_W-1:0] atan_val(input int idx);
    logic [ANG_W-1:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gfc_if.sv */
// gfc channel interfaces: pitch words in, compensation words out
// depends on gfc_pkg
`default_nettype none

interface gfc_pitch_if;
  logic                                valid;
  logic                                ready;
  logic signed [gfc_pkg::DATA_W-1:0]   pitch_angle;
  modport source(output valid, output pitch_angle, input ready);
  modport sink(input valid, input pitch_angle, output ready);
endinterface

interface gfc_comp_if;
  logic                                valid;
  logic                                ready;
  logic signed [gfc_pkg::DATA_W-1:0]   comp_offset;
  modport source(output valid, output comp_offset, input ready);
  modport sink(input valid, input comp_offset, output ready);
endinterface

`default_nettype wire

/* rtl/core/gfc_vec_stage.sv */
// gfc_vec_stage: one vectoring cordic iteration with its own register
// depends on gfc_pkg
`default_nettype none

module gfc_vec_stage #(
  parameter int STAGE = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_up,
  input  wire gfc_pkg::vec_t data_up,
  output logic               ready_up,
  output logic               valid_dn,
  output gfc_pkg::vec_t      data_dn,
  input  wire logic          ready_dn
);

  gfc_pkg::vec_t                      data_next;
  logic signed [gfc_pkg::VEC_W-1:0]   dx;
  logic signed [gfc_pkg::VEC_W-1:0]   dz;

  assign dx       = data_up.vz >>> STAGE;
  assign dz       = data_up.vx >>> STAGE;
  assign ready_up = !valid_dn || ready_dn;

  always_comb begin
    data_next = data_up;
    if (!data_up.hold) begin
      if (!data_up.vz[gfc_pkg::VEC_W-1]) begin
        data_next.vx  = data_up.vx + dx;
        data_next.vz  = data_up.vz - dz;
        data_next.acc = data_up.acc + gfc_pkg::atan_val(STAGE);
      end else begin
        data_next.vx  = data_up.vx - dx;
        data_next.vz  = data_up.vz + dz;
        data_next.acc = data_up.acc - gfc_pkg::atan_val(STAGE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_dn <= 1'b0;
    end else if (ready_up) begin
      valid_dn <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      data_dn <= data_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gfc_rot_stage.sv */
// gfc_rot_stage: one rotation cordic iteration with its own register
// depends on gfc_pkg
`default_nettype none

module gfc_rot_stage #(
  parameter int STAGE = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_up,
  input  wire gfc_pkg::rot_t data_up,
  output logic               ready_up,
  output logic               valid_dn,
  output gfc_pkg::rot_t      data_dn,
  input  wire logic          ready_dn
);

  gfc_pkg::rot_t                      data_next;
  logic signed [gfc_pkg::ROT_W-1:0]   dx;
  logic signed [gfc_pkg::ROT_W-1:0]   dy;
  logic signed [gfc_pkg::ROT_W-1:0]   step;

  assign dx       = data_up.y >>> STAGE;
  assign dy       = data_up.x >>> STAGE;
  assign step     = $signed({1'b0, gfc_pkg::atan_val(STAGE)});
  assign ready_up = !valid_dn || ready_dn;

  always_comb begin
    data_next = data_up;
    if (!data_up.r[gfc_pkg::ROT_W-1]) begin
      data_next.x = data_up.x - dx;
      data_next.y = data_up.y + dy;
      data_next.r = data_up.r - step;
    end else begin
      data_next.x = data_up.x + dx;
      data_next.y = data_up.y - dy;
      data_next.r = data_up.r + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_dn <= 1'b0;
    end else if (ready_up) begin
      valid_dn <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      data_dn <= data_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gfc_scale.sv */
// gfc_scale: sign fix, multiply by comp_max, round and clamp, output register
// depends on gfc_pkg and gfc_if
`default_nettype none

module gfc_scale (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid_up,
  input  wire gfc_pkg::rot_t data_up,
  output logic               ready_up,
  gfc_comp_if.source         comp
);

  localparam int PROD_W = gfc_pkg::ROT_W + gfc_pkg::DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RES_W  = 20;
  localparam logic signed [SUM_W-1:0] RND = SUM_W'(64'sd536870912);

  // stage 1: signed cosine
  logic                               s1_valid;
  logic signed [gfc_pkg::ROT_W-1:0]   s1_cos;
  logic                               s1_zero;
  logic signed [gfc_pkg::DATA_W-1:0]  s1_m;
  logic                               s1_ready;

  // stage 2: product
  logic                               s2_valid;
  logic signed [PROD_W-1:0]           s2_prod;
  logic                               s2_zero;
  logic [gfc_pkg::DATA_W-1:0]         s2_lim;
  logic                               s2_ready;

  logic                               s3_ready;
  logic signed [SUM_W-1:0]            sum;
  logic signed [RES_W-1:0]            rounded;
  logic signed [RES_W-1:0]            lim_pos;
  logic signed [RES_W-1:0]            lim_neg;
  logic signed [RES_W-1:0]            res_next;

  assign s3_ready = !comp.valid || comp.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign ready_up = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      comp.valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= valid_up;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        comp.valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_cos  <= data_up.flip ? -data_up.x : data_up.x;
      s1_zero <= data_up.zero;
      s1_m    <= data_up.m;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_prod <= PROD_W'(s1_cos) * PROD_W'(s1_m);
      s2_zero <= s1_zero;
      s2_lim  <= s1_m[gfc_pkg::DATA_W-1] ? -s1_m : s1_m;
    end
  end

  assign sum     = SUM_W'(s2_prod) + RND;
  assign rounded = sum[SUM_W-1 -: RES_W];
  assign lim_pos = $signed({{(RES_W-gfc_pkg::DATA_W){1'b0}}, s2_lim});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (s2_zero) begin
      res_next = '0;
    end else if (rounded > lim_pos) begin
      res_next = lim_pos;
    end else if (rounded < lim_neg) begin
      res_next = lim_neg;
    end else begin
      res_next = rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      comp.comp_offset <= res_next[gfc_pkg::DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gravity_feedforward_cosine.sv */
// gravity_feedforward_cosine: comp_max * cos(polar angle of cg offset + pitch)
// depends on gfc_pkg, gfc_if, gfc_vec_stage, gfc_rot_stage, gfc_scale
//
//   channel   dir  handshake        payload
//   pitch     in   valid / ready    pitch_angle  s16, 65536 steps per turn
//   comp      out  valid / ready    comp_offset  s16
//   cfg       in   cfg_write        cfg_index, cfg_data (0 cg_x, 1 cg_z, 2 comp_max)
//
// one word per cycle sustained while comp.ready holds; registers, in order:
// entry register, vectoring iterations, angle register, rotation iterations,
// then sign, multiply and round/clamp registers
// each stage holds its word while the next one is full; bubbles close up
// synchronous reset clears the valid bits and the configuration registers
`default_nettype none

module gravity_feedforward_cosine #(
  parameter int CORDIC_STAGES = gfc_pkg::STAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [gfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gfc_pkg::DATA_W-1:0]     cfg_data,
  gfc_pitch_if.sink                           pitch,
  gfc_comp_if.source                          comp
);

  localparam int N = CORDIC_STAGES;
  localparam int EXT = gfc_pkg::VEC_W - gfc_pkg::DATA_W - 1 - 16;

  logic signed [gfc_pkg::DATA_W-1:0] cg_x;
  logic signed [gfc_pkg::DATA_W-1:0] cg_z;
  logic signed [gfc_pkg::DATA_W-1:0] comp_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      cg_x     <= '0;
      cg_z     <= '0;
      comp_max <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        gfc_pkg::REG_CG_X:     cg_x     <= cfg_data;
        gfc_pkg::REG_CG_Z:     cg_z     <= cfg_data;
        gfc_pkg::REG_COMP_MAX: comp_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry word
  gfc_pkg::vec_t                      entry_next;
  logic signed [gfc_pkg::DATA_W:0]    xa;
  logic signed [gfc_pkg::DATA_W:0]    za;

  always_comb begin
    xa = {cg_x[gfc_pkg::DATA_W-1], cg_x};
    za = {cg_z[gfc_pkg::DATA_W-1], cg_z};
    if (cg_x[gfc_pkg::DATA_W-1]) begin
      xa = -xa;
      za = -za;
    end
    entry_next.vx    = {{EXT{xa[gfc_pkg::DATA_W]}}, xa, 16'h0000};
    entry_next.vz    = {{EXT{za[gfc_pkg::DATA_W]}}, za, 16'h0000};
    entry_next.hold  = (cg_x == '0);
    entry_next.zero  = (cg_x == '0) && (cg_z == '0);
    entry_next.pitch = pitch.pitch_angle;
    if (cg_x == '0) begin
      entry_next.acc = cg_z[gfc_pkg::DATA_W-1] ? gfc_pkg::ANG_NEG90 : gfc_pkg::ANG_POS90;
    end else begin
      entry_next.acc = cg_x[gfc_pkg::DATA_W-1] ? gfc_pkg::ANG_180 : gfc_pkg::ANG_ZERO;
    end
    if (comp_max == {1'b1, {(gfc_pkg::DATA_W-1){1'b0}}}) begin
      entry_next.m = {1'b1, {(gfc_pkg::DATA_W-2){1'b0}}, 1'b1};
    end else begin
      entry_next.m = comp_max;
    end
  end

  gfc_pkg::vec_t vs       [0:N];
  logic          vs_valid [0:N];
  logic          vs_rdy   [0:N];

  gfc_pkg::rot_t rs       [0:N];
  logic          rs_valid [0:N];
  logic          rs_rdy   [0:N];

  logic          scale_rdy;

  assign vs_rdy[0]   = !vs_valid[0] || vs_rdy[1];
  assign pitch.ready = vs_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs_valid[0] <= 1'b0;
    end else if (vs_rdy[0]) begin
      vs_valid[0] <= pitch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vs_rdy[0]) begin
      vs[0] <= entry_next;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= N; k++) begin : g_vec
      logic rdy_dn;
      if (k == N) begin : g_last
        assign rdy_dn = rs_rdy[0];
      end else begin : g_mid
        assign rdy_dn = vs_rdy[k+1];
      end
      gfc_vec_stage #(.STAGE(k-1)) u_vec (
        .clk      (clk),
        .rst      (rst),
        .valid_up (vs_valid[k-1]),
        .data_up  (vs[k-1]),
        .ready_up (vs_rdy[k]),
        .valid_dn (vs_valid[k]),
        .data_dn  (vs[k]),
        .ready_dn (rdy_dn)
      );
    end
  endgenerate

  // angle word: fold into +-90 degrees
  gfc_pkg::rot_t            rot_next;
  logic [gfc_pkg::ANG_W-1:0] theta;
  logic [gfc_pkg::ANG_W-1:0] theta_f;
  logic                      flip;

  assign theta   = vs[N].acc + {vs[N].pitch, 16'h0000};
  assign flip    = theta[gfc_pkg::ANG_W-1] ^ theta[gfc_pkg::ANG_W-2];
  assign theta_f = flip ? (theta ^ gfc_pkg::ANG_180) : theta;

  always_comb begin
    rot_next.x    = gfc_pkg::INV_GAIN;
    rot_next.y    = '0;
    rot_next.r    = {theta_f[gfc_pkg::ANG_W-1], theta_f};
    rot_next.flip = flip;
    rot_next.zero = vs[N].zero;
    rot_next.m    = vs[N].m;
  end

  assign rs_rdy[0] = !rs_valid[0] || rs_rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_valid[0] <= 1'b0;
    end else if (rs_rdy[0]) begin
      rs_valid[0] <= vs_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (rs_rdy[0]) begin
      rs[0] <= rot_next;
    end
  end

  generate
    for (k = 1; k <= N; k++) begin : g_rot
      logic rdy_dn;
      if (k == N) begin : g_last
        assign rdy_dn = scale_rdy;
      end else begin : g_mid
        assign rdy_dn = rs_rdy[k+1];
      end
      gfc_rot_stage #(.STAGE(k-1)) u_rot (
        .clk      (clk),
        .rst      (rst),
        .valid_up (rs_valid[k-1]),
        .data_up  (rs[k-1]),
        .ready_up (rs_rdy[k]),
        .valid_dn (rs_valid[k]),
        .data_dn  (rs[k]),
        .ready_dn (rdy_dn)
      );
    end
  endgenerate

  gfc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .valid_up (rs_valid[N]),
    .data_up  (rs[N]),
    .ready_up (scale_rdy),
    .comp     (comp)
  );

endmodule

`default_nettype wire
